FILE: design/fsima_pkg.sv
// ----------------------------------------------------------------------------
// fsima_pkg
// Shared types, constants and tables of the four-stem IMA-ADPCM mixer.
// ----------------------------------------------------------------------------
package fsima_pkg;

    localparam int NUM_STEMS = 4;
    localparam int NUM_CH    = 2 * NUM_STEMS;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;

    localparam logic [6:0] STEP_MAX   = 7'd88;
    localparam logic [8:0] GAIN_UNITY = 9'd256;

    typedef logic [8:0]         t_gain;
    typedef logic signed [15:0] t_pred;
    typedef logic signed [16:0] t_scaled;

    typedef enum logic [1:0] {
        MODE_DECODE   = 2'd0,
        MODE_CLEAR    = 2'd1,
        MODE_SNAPSHOT = 2'd2,
        MODE_RESTORE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_STEM0 = 3'd0,
        CFG_GAIN_STEM1 = 3'd1,
        CFG_GAIN_STEM2 = 3'd2,
        CFG_GAIN_STEM3 = 3'd3
    } t_cfg_idx;

    // Load strobes of the three pipeline stages
    typedef struct packed {
        logic ld_dec;
        logic ld_scale;
        logic ld_out;
    } t_pipe_ctl;

    function automatic logic signed [4:0] index_move(input logic [2:0] mag);
        logic signed [4:0] mv;
        case (mag)
            3'd4:    mv = 5'sd2;
            3'd5:    mv = 5'sd4;
            3'd6:    mv = 5'sd6;
            3'd7:    mv = 5'sd8;
            default: mv = -5'sd1;
        endcase
        return mv;
    endfunction

    function automatic logic [14:0] step_size(input logic [6:0] idx);
        logic [14:0] s;
        case (idx)
            7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
            7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
            7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
            7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
            7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
            7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
            7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
            7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
            7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
            7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
            7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
            7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
            7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
            7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
            7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
            7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
            7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
            7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
            7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
            7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
            7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
            7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
            7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
            7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
            7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
            7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
            7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
            7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
            7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
            7'd87: s = 15'd29794;
            default: s = 15'd32767;
        endcase
        return s;
    endfunction

endpackage

FILE: design/fsima_if.sv
// ----------------------------------------------------------------------------
// fsima_if
// Valid/ready channels of the mixer: nibble frames in, mixed samples out.
// ----------------------------------------------------------------------------
interface fsima_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [3:0] nib_s0_left;
    logic [3:0] nib_s0_right;
    logic [3:0] nib_s1_left;
    logic [3:0] nib_s1_right;
    logic [3:0] nib_s2_left;
    logic [3:0] nib_s2_right;
    logic [3:0] nib_s3_left;
    logic [3:0] nib_s3_right;

    modport source (
        output valid, mode, nib_s0_left, nib_s0_right, nib_s1_left, nib_s1_right,
               nib_s2_left, nib_s2_right, nib_s3_left, nib_s3_right,
        input  ready
    );
    modport sink (
        input  valid, mode, nib_s0_left, nib_s0_right, nib_s1_left, nib_s1_right,
               nib_s2_left, nib_s2_right, nib_s3_left, nib_s3_right,
        output ready
    );
endinterface

interface fsima_out_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] left_sample;
    logic signed [23:0] right_sample;
    logic [15:0]        frame_peak;

    modport source (
        output valid, left_sample, right_sample, frame_peak,
        input  ready
    );
    modport sink (
        input  valid, left_sample, right_sample, frame_peak,
        output ready
    );
endinterface

FILE: design/four_stem_ima_adpcm_mixer_unit.sv
// ----------------------------------------------------------------------------
// four_stem_ima_adpcm_mixer_unit
// Eight IMA-ADPCM decoders with stem faders, mixed down to one stereo frame.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  i_in      in   valid / ready      mode, nib_s0_left .. nib_s3_right
//  o_out     out  valid / ready      left_sample, right_sample, frame_peak
//  cfg       in   i_cfg_we           i_cfg_idx, i_cfg_data (stem gains)
//
//  One frame per cycle while o_out takes results. Three stages: decode and
//  state update, gain multiply, mix and peak; an accepted item passes the
//  decode, scale and out registers in order, and o_out.valid is the out flag.
//  Decoder state advances at acceptance, so the per-channel predictor loop
//  closes within the decode stage. Reset is synchronous, clears state, gains to unity.
//  Back-pressure on o_out fills the three stages before i_in.ready drops.
// ----------------------------------------------------------------------------
module four_stem_ima_adpcm_mixer_unit
    import fsima_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    fsima_in_if.sink              i_in,
    fsima_out_if.source           o_out
);

    t_gain      r_gain [NUM_STEMS];
    logic       r_v1;
    logic       r_v2;
    logic       r_v3;

    t_pipe_ctl  ctl;
    logic       en2;
    logic       en3;
    t_gain      cfg_gain;
    t_mode      mode;
    logic [3:0] code   [NUM_CH];
    t_scaled    scaled [NUM_CH];

    // gain registers, values above unity act as unity
    assign cfg_gain = (i_cfg_data > GAIN_UNITY) ? GAIN_UNITY : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_STEMS; k++) begin
                r_gain[k] <= GAIN_UNITY;
            end
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_GAIN_STEM0: r_gain[0] <= cfg_gain;
                CFG_GAIN_STEM1: r_gain[1] <= cfg_gain;
                CFG_GAIN_STEM2: r_gain[2] <= cfg_gain;
                CFG_GAIN_STEM3: r_gain[3] <= cfg_gain;
                default: begin
                    r_gain[0] <= r_gain[0];
                end
            endcase
        end
    end

    // pipeline flow: a stage loads when the one after it is free or moving
    always_comb begin
        en3          = !r_v3 || o_out.ready;
        en2          = !r_v2 || en3;
        i_in.ready   = !r_v1 || en2;
        ctl.ld_dec   = i_in.valid && i_in.ready;
        ctl.ld_scale = r_v1 && en2;
        ctl.ld_out   = r_v2 && en3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ctl.ld_dec) begin
                r_v1 <= 1'b1;
            end else if (ctl.ld_scale) begin
                r_v1 <= 1'b0;
            end
            if (ctl.ld_scale) begin
                r_v2 <= 1'b1;
            end else if (ctl.ld_out) begin
                r_v2 <= 1'b0;
            end
            if (ctl.ld_out) begin
                r_v3 <= 1'b1;
            end else if (o_out.ready) begin
                r_v3 <= 1'b0;
            end
        end
    end

    assign mode    = t_mode'(i_in.mode);
    assign code[0] = i_in.nib_s0_left;
    assign code[1] = i_in.nib_s0_right;
    assign code[2] = i_in.nib_s1_left;
    assign code[3] = i_in.nib_s1_right;
    assign code[4] = i_in.nib_s2_left;
    assign code[5] = i_in.nib_s2_right;
    assign code[6] = i_in.nib_s3_left;
    assign code[7] = i_in.nib_s3_right;

    // channel 2*stem + side, side 0 is left
    for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
        fsima_lane u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_mode   (mode),
            .i_code   (code[ch]),
            .i_gain   (r_gain[ch/2]),
            .o_scaled (scaled[ch])
        );
    end

    fsima_merge u_merge (
        .i_clk    (i_clk),
        .i_ctl    (ctl),
        .i_scaled (scaled),
        .o_left   (o_out.left_sample),
        .o_right  (o_out.right_sample),
        .o_peak   (o_out.frame_peak)
    );

    assign o_out.valid = r_v3;

    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_v1 && r_v2 && r_v3 && !o_out.ready))
        else $error("input stalled with room in the pipeline");

    a_result_follows_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.ld_out |=> o_out.valid)
        else $error("mix stage loaded but no result presented");

    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.frame_peak <= 16'd32768))
        else $error("frame peak out of range");

    a_low_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.left_sample[7:0] == 8'd0 && o_out.right_sample[7:0] == 8'd0))
        else $error("sample low byte not zero");

endmodule

FILE: design/fsima_lane.sv
// ----------------------------------------------------------------------------
// fsima_lane
// One decoder channel: IMA state update, clear, snapshot and restore, and stem gain scaling.
// ----------------------------------------------------------------------------
module fsima_lane
    import fsima_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_pipe_ctl i_ctl,
    input  t_mode     i_mode,
    input  logic [3:0] i_code,
    input  t_gain     i_gain,
    output t_scaled   o_scaled
);

    t_pred       r_pred;
    logic [6:0]  r_idx;
    t_pred       r_save_pred;
    logic [6:0]  r_save_idx;
    t_pred       r_sample;
    t_scaled     r_scaled;

    logic [14:0]        step;
    logic [16:0]        diff;
    logic signed [17:0] sum;
    logic signed [7:0]  idx_sum;
    t_pred              n_pred;
    logic [6:0]         n_idx;
    logic signed [25:0] prod;

    always_comb begin
        step = step_size(r_idx);
        diff = {5'd0, step[14:3]};
        if (i_code[2]) begin
            diff = diff + {2'd0, step};
        end
        if (i_code[1]) begin
            diff = diff + {3'd0, step[14:1]};
        end
        if (i_code[0]) begin
            diff = diff + {4'd0, step[14:2]};
        end
        if (i_code[3]) begin
            sum = {{2{r_pred[15]}}, r_pred} - $signed({1'b0, diff});
        end else begin
            sum = {{2{r_pred[15]}}, r_pred} + $signed({1'b0, diff});
        end
        if (sum > 18'sd32767) begin
            n_pred = 16'sh7FFF;
        end else if (sum < -18'sd32768) begin
            n_pred = 16'sh8000;
        end else begin
            n_pred = sum[15:0];
        end

        idx_sum = $signed({1'b0, r_idx}) + 8'(index_move(i_code[2:0]));
        if (idx_sum < 8'sd0) begin
            n_idx = 7'd0;
        end else if (idx_sum > $signed({1'b0, STEP_MAX})) begin
            n_idx = STEP_MAX;
        end else begin
            n_idx = idx_sum[6:0];
        end

        prod = r_sample * $signed({1'b0, i_gain});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pred      <= '0;
            r_idx       <= '0;
            r_save_pred <= '0;
            r_save_idx  <= '0;
        end else if (i_ctl.ld_dec) begin
            case (i_mode)
                MODE_DECODE: begin
                    r_pred <= n_pred;
                    r_idx  <= n_idx;
                end
                MODE_CLEAR: begin
                    r_pred <= '0;
                    r_idx  <= '0;
                end
                MODE_SNAPSHOT: begin
                    r_save_pred <= r_pred;
                    r_save_idx  <= r_idx;
                end
                MODE_RESTORE: begin
                    r_pred <= r_save_pred;
                    r_idx  <= r_save_idx;
                end
                default: begin
                    r_pred <= r_pred;
                end
            endcase
        end
    end

    // non-decode items carry a zero sample, so the mix comes out as zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_dec) begin
            r_sample <= (i_mode == MODE_DECODE) ? n_pred : '0;
        end
        if (i_ctl.ld_scale) begin
            r_scaled <= prod[24:8];
        end
    end

    assign o_scaled = r_scaled;

endmodule

FILE: design/fsima_merge.sv
// ----------------------------------------------------------------------------
// fsima_merge
// Sums the four stems of each side, scales, clamps and finds the frame peak.
// ----------------------------------------------------------------------------
module fsima_merge
    import fsima_pkg::*;
(
    input  logic               i_clk,
    input  t_pipe_ctl          i_ctl,
    input  t_scaled            i_scaled [NUM_CH],
    output logic signed [23:0] o_left,
    output logic signed [23:0] o_right,
    output logic [15:0]        o_peak
);

    logic signed [23:0] r_left;
    logic signed [23:0] r_right;
    logic [15:0]        r_peak;

    logic signed [18:0] sum   [2];
    t_pred              mixed [2];
    logic [15:0]        mag   [2];
    logic signed [16:0] neg;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            sum[s] = '0;
            for (int k = 0; k < NUM_STEMS; k++) begin
                sum[s] = sum[s] + 19'(i_scaled[2*k + s]);
            end
            // floor shift by two, then clamp to 16 bits
            if ($signed(sum[s][18:2]) > 17'sd32767) begin
                mixed[s] = 16'sh7FFF;
            end else if ($signed(sum[s][18:2]) < -17'sd32768) begin
                mixed[s] = 16'sh8000;
            end else begin
                mixed[s] = sum[s][17:2];
            end
        end
        for (int s = 0; s < 2; s++) begin
            neg    = -{mixed[s][15], mixed[s]};
            mag[s] = mixed[s][15] ? neg[15:0] : mixed[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld_out) begin
            r_left  <= {mixed[0], 8'd0};
            r_right <= {mixed[1], 8'd0};
            r_peak  <= (mag[0] > mag[1]) ? mag[0] : mag[1];
        end
    end

    assign o_left  = r_left;
    assign o_right = r_right;
    assign o_peak  = r_peak;

endmodule
